[hdl/bbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// shared types, codes and sizes of the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH   = 32;
  localparam int POSITION_BITS = 32;
  localparam int IN_POS_W      = 32;
  localparam int OUT_POS_W     = 32;
  localparam int WIDE_W        = 64;
  localparam int IN_TDATA_W    = 40;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 40;
  localparam int OUT_TUSER_W   = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_LW      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] CLS_OPEN  = 2'd1;
  localparam logic [1:0] CLS_CLOSE = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_END  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_UNCLOSED = 3'd1,
    STAT_EXCESS   = 3'd2,
    STAT_MISMATCH = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_RUN    = 3'b001,
    S_DRAIN  = 3'b010,
    S_CLOSER = 3'b100
  } state_e;

  typedef struct packed {
    logic       valid;
    op_e        op;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic [QUEUE_LW-1:0] level;
  } fr_stat_t;

  typedef struct packed {
    logic draining;
    logic settling;
  } bk_stat_t;

endpackage

[hdl/bbc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_front
// accepts tokens, drops plain tokens and queues stack commands for the back
// ----------------------------------------------------------------------------
module bbc_front #(
  parameter int POSITION_BITS = bbc_pkg::POSITION_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        tok_valid_i,
  output logic                        tok_ready_o,
  input  logic                        tok_end_i,
  input  logic [1:0]                  tok_class_i,
  input  logic [1:0]                  tok_kind_i,
  input  logic [bbc_pkg::IN_POS_W-1:0] tok_pos_i,
  output bbc_pkg::cmd_t               cmd_o,
  output logic [POSITION_BITS-1:0]    cmd_pos_o,
  input  logic                        cmd_pop_i,
  output bbc_pkg::fr_stat_t           stat_o
);

  localparam int QD = bbc_pkg::QUEUE_DEPTH;
  localparam int QA = bbc_pkg::QUEUE_AW;
  localparam int QL = bbc_pkg::QUEUE_LW;

  bbc_pkg::cmd_t              q_cmd_q [QD];
  logic [POSITION_BITS-1:0]   q_pos_q [QD];
  logic [QA-1:0]              wr_ptr_q, wr_ptr_d;
  logic [QA-1:0]              rd_ptr_q, rd_ptr_d;
  logic [QL-1:0]              level_q, level_d;

  logic                       accept;
  logic                       keep;
  logic                       push;
  logic                       pop;
  bbc_pkg::cmd_t              new_cmd;
  logic [bbc_pkg::WIDE_W-1:0] pos_wide;

  assign tok_ready_o = (level_q != QL'(QD));
  assign accept      = tok_valid_i && tok_ready_o;
  assign keep        = tok_end_i || (tok_class_i == bbc_pkg::CLS_OPEN) ||
                       (tok_class_i == bbc_pkg::CLS_CLOSE);
  assign push        = accept && keep;
  assign pop         = cmd_pop_i && (level_q != '0);
  assign pos_wide    = bbc_pkg::WIDE_W'(tok_pos_i);

  always_comb begin
    new_cmd.valid = 1'b1;
    new_cmd.kind  = tok_kind_i;
    if (tok_end_i) begin
      new_cmd.op = bbc_pkg::OP_END;
    end else if (tok_class_i == bbc_pkg::CLS_OPEN) begin
      new_cmd.op = bbc_pkg::OP_PUSH;
    end else begin
      new_cmd.op = bbc_pkg::OP_POP;
    end
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QA'(QD - 1)) ? '0 : wr_ptr_q + QA'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QA'(QD - 1)) ? '0 : rd_ptr_q + QA'(1);
    end
    if (push && !pop) begin
      level_d = level_q + QL'(1);
    end else if (pop && !push) begin
      level_d = level_q - QL'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_cmd_q[wr_ptr_q] <= new_cmd;
      q_pos_q[wr_ptr_q] <= pos_wide[POSITION_BITS-1:0];
    end
  end

  always_comb begin
    cmd_o       = q_cmd_q[rd_ptr_q];
    cmd_o.valid = (level_q != '0);
  end

  assign cmd_pos_o    = q_pos_q[rd_ptr_q];
  assign stat_o.level = level_q;

endmodule

[hdl/bbc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_back
// bracket stack, error tracking and the verdict drain at the end of a query
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int STACK_DEPTH   = bbc_pkg::STACK_DEPTH,
  parameter int POSITION_BITS = bbc_pkg::POSITION_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bbc_pkg::cmd_t                cmd_i,
  input  logic [POSITION_BITS-1:0]     cmd_pos_i,
  output logic                         cmd_pop_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output logic [2:0]                   res_status_o,
  output logic                         res_has_entry_o,
  output logic [1:0]                   res_kind_o,
  output logic                         res_closing_o,
  output logic [bbc_pkg::OUT_POS_W-1:0] res_pos_o,
  output logic                         res_last_o,
  output bbc_pkg::bk_stat_t            stat_o
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int MW = POSITION_BITS + 2;

  logic [MW-1:0]            mem [STACK_DEPTH];
  logic [MW-1:0]            rd_q;
  logic [AW-1:0]            rd_addr;
  logic                     mem_we;

  bbc_pkg::state_e          state_q, state_d;
  bbc_pkg::status_e         err_q, err_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            idx_q, idx_d;
  logic                     rdok_q, rdok_d;
  logic                     wait_q, wait_d;
  logic [1:0]               off_kind_q, off_kind_d;
  logic [POSITION_BITS-1:0] off_pos_q, off_pos_d;

  logic                     ov_q, ov_d;
  bbc_pkg::status_e         os_q, os_d;
  logic                     oh_q, oh_d;
  logic [1:0]               ok_q, ok_d;
  logic                     oc_q, oc_d;
  logic [POSITION_BITS-1:0] op_q, op_d;
  logic                     ol_q, ol_d;

  logic                     slot_free;
  logic                     load;
  logic [CW-1:0]            top_idx;
  logic [1:0]               rd_kind;
  logic [POSITION_BITS-1:0] rd_pos;
  logic [bbc_pkg::WIDE_W-1:0] out_wide;

  assign slot_free = !ov_q || res_ready_i;
  assign top_idx   = count_q - CW'(1);
  assign rd_kind   = rd_q[MW-1:POSITION_BITS];
  assign rd_pos    = rd_q[POSITION_BITS-1:0];
  assign rd_addr   = (state_q == bbc_pkg::S_DRAIN) ? idx_q[AW-1:0] : top_idx[AW-1:0];

  always_comb begin
    state_d    = state_q;
    err_d      = err_q;
    count_d    = count_q;
    idx_d      = idx_q;
    rdok_d     = rdok_q;
    wait_d     = 1'b0;
    off_kind_d = off_kind_q;
    off_pos_d  = off_pos_q;
    mem_we     = 1'b0;
    cmd_pop_o  = 1'b0;
    load       = 1'b0;
    os_d       = os_q;
    oh_d       = oh_q;
    ok_d       = ok_q;
    oc_d       = oc_q;
    op_d       = op_q;
    ol_d       = ol_q;

    unique case (state_q)
      bbc_pkg::S_RUN: begin
        if (cmd_i.valid && !wait_q) begin
          case (cmd_i.op)
            bbc_pkg::OP_PUSH: begin
              cmd_pop_o = 1'b1;
              if (err_q == bbc_pkg::STAT_OK) begin
                if (count_q == CW'(STACK_DEPTH)) begin
                  err_d      = bbc_pkg::STAT_OVERFLOW;
                  off_kind_d = cmd_i.kind;
                  off_pos_d  = cmd_pos_i;
                end else begin
                  mem_we  = 1'b1;
                  count_d = count_q + CW'(1);
                  wait_d  = 1'b1;
                end
              end
            end
            bbc_pkg::OP_POP: begin
              cmd_pop_o = 1'b1;
              if (err_q == bbc_pkg::STAT_OK) begin
                if (count_q == '0) begin
                  err_d      = bbc_pkg::STAT_EXCESS;
                  off_kind_d = cmd_i.kind;
                  off_pos_d  = cmd_pos_i;
                end else if (rd_kind == cmd_i.kind) begin
                  count_d = top_idx;
                  wait_d  = 1'b1;
                end else begin
                  err_d      = bbc_pkg::STAT_MISMATCH;
                  off_kind_d = cmd_i.kind;
                  off_pos_d  = cmd_pos_i;
                end
              end
            end
            bbc_pkg::OP_END: begin
              if (err_q == bbc_pkg::STAT_OVERFLOW) begin
                if (slot_free) begin
                  cmd_pop_o = 1'b1;
                  load      = 1'b1;
                  os_d      = bbc_pkg::STAT_OVERFLOW;
                  oh_d      = 1'b1;
                  ok_d      = off_kind_q;
                  oc_d      = 1'b0;
                  op_d      = off_pos_q;
                  ol_d      = 1'b1;
                  count_d    = '0;
                  err_d      = bbc_pkg::STAT_OK;
                  off_kind_d = '0;
                  off_pos_d  = '0;
                end
              end else if (err_q != bbc_pkg::STAT_OK) begin
                cmd_pop_o = 1'b1;
                idx_d     = '0;
                rdok_d    = 1'b0;
                state_d   = (count_q != '0) ? bbc_pkg::S_DRAIN : bbc_pkg::S_CLOSER;
              end else if (count_q == '0) begin
                if (slot_free) begin
                  cmd_pop_o = 1'b1;
                  load      = 1'b1;
                  os_d      = bbc_pkg::STAT_OK;
                  oh_d      = 1'b0;
                  ok_d      = '0;
                  oc_d      = 1'b0;
                  op_d      = '0;
                  ol_d      = 1'b1;
                end
              end else begin
                cmd_pop_o = 1'b1;
                idx_d     = '0;
                rdok_d    = 1'b0;
                state_d   = bbc_pkg::S_DRAIN;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      bbc_pkg::S_DRAIN: begin
        rdok_d = 1'b1;
        if (rdok_q && slot_free) begin
          load   = 1'b1;
          os_d   = (err_q == bbc_pkg::STAT_OK) ? bbc_pkg::STAT_UNCLOSED : err_q;
          oh_d   = 1'b1;
          ok_d   = rd_kind;
          oc_d   = 1'b0;
          op_d   = rd_pos;
          ol_d   = (err_q == bbc_pkg::STAT_OK) && (idx_q == top_idx);
          rdok_d = 1'b0;
          idx_d  = idx_q + CW'(1);
          if (idx_q == top_idx) begin
            if (err_q == bbc_pkg::STAT_OK) begin
              state_d    = bbc_pkg::S_RUN;
              count_d    = '0;
              off_kind_d = '0;
              off_pos_d  = '0;
            end else begin
              state_d = bbc_pkg::S_CLOSER;
            end
          end
        end
      end
      bbc_pkg::S_CLOSER: begin
        if (slot_free) begin
          load       = 1'b1;
          os_d       = err_q;
          oh_d       = 1'b1;
          ok_d       = off_kind_q;
          oc_d       = 1'b1;
          op_d       = off_pos_q;
          ol_d       = 1'b1;
          state_d    = bbc_pkg::S_RUN;
          count_d    = '0;
          err_d      = bbc_pkg::STAT_OK;
          off_kind_d = '0;
          off_pos_d  = '0;
        end
      end
      default: begin
        state_d = bbc_pkg::S_RUN;
      end
    endcase

    if (load) begin
      ov_d = 1'b1;
    end else if (res_ready_i) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bbc_pkg::S_RUN;
      err_q      <= bbc_pkg::STAT_OK;
      count_q    <= '0;
      idx_q      <= '0;
      rdok_q     <= 1'b0;
      wait_q     <= 1'b0;
      off_kind_q <= '0;
      off_pos_q  <= '0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      err_q      <= err_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      rdok_q     <= rdok_d;
      wait_q     <= wait_d;
      off_kind_q <= off_kind_d;
      off_pos_q  <= off_pos_d;
      ov_q       <= ov_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    os_q <= os_d;
    oh_q <= oh_d;
    ok_q <= ok_d;
    oc_q <= oc_d;
    op_q <= op_d;
    ol_q <= ol_d;
  end

  // stack memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= {cmd_i.kind, cmd_pos_i};
    end
    rd_q <= mem[rd_addr];
  end

  assign out_wide        = bbc_pkg::WIDE_W'(op_q);
  assign res_valid_o     = ov_q;
  assign res_status_o    = os_q;
  assign res_has_entry_o = oh_q;
  assign res_kind_o      = ok_q;
  assign res_closing_o   = oc_q;
  assign res_pos_o       = out_wide[bbc_pkg::OUT_POS_W-1:0];
  assign res_last_o      = ol_q;

  assign stat_o.draining = (state_q != bbc_pkg::S_RUN);
  assign stat_o.settling = wait_q;

endmodule

[hdl/bracket_balance_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker
// checks round, square and curly bracket nesting of a token stream
// ----------------------------------------------------------------------------
//  channel   dir  tdata                             tuser              tlast
//  s_axis    in   kind[1:0] position[33:2]          token_class[1:0]   end_of_query
//  m_axis    out  kind[1:0] closing[2] pos[34:3]    status[2:0] has[3] last_result
//
//  the front takes one item per cycle while its four-entry queue has room;
//  plain tokens are dropped there
//  after an opener or closer the back waits while the new top-of-stack kind
//  is fetched from the registered read port of the stack memory
//  at the end marker each reported entry is first read through the same port
//  the stack memory has no reset and no clearing pass; control state resets
//  either side may stall without loss: the queue and the result register part them
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
  parameter int STACK_DEPTH   = bbc_pkg::STACK_DEPTH,
  parameter int POSITION_BITS = bbc_pkg::POSITION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [bbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // bracket_kind, token_position
  input  logic [bbc_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,  // token_class
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [bbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,  // entry_kind, entry_closing,
                                                           // entry_position
  output logic [bbc_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,  // status, has_entry
  output logic                            m_axis_tlast_o
);

  localparam int PW = bbc_pkg::OUT_POS_W;

  bbc_pkg::cmd_t            cmd;
  logic [POSITION_BITS-1:0] cmd_pos;
  logic                     cmd_pop;
  bbc_pkg::fr_stat_t        fr_stat;
  bbc_pkg::bk_stat_t        bk_stat;

  logic [2:0]               res_status;
  logic                     res_has;
  logic [1:0]               res_kind;
  logic                     res_closing;
  logic [PW-1:0]            res_pos;

  bbc_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (s_axis_tvalid_i),
    .tok_ready_o (s_axis_tready_o),
    .tok_end_i   (s_axis_tlast_i),
    .tok_class_i (s_axis_tuser_i),
    .tok_kind_i  (s_axis_tdata_i[1:0]),
    .tok_pos_i   (s_axis_tdata_i[bbc_pkg::IN_POS_W+1:2]),
    .cmd_o       (cmd),
    .cmd_pos_o   (cmd_pos),
    .cmd_pop_i   (cmd_pop),
    .stat_o      (fr_stat)
  );

  bbc_back #(
    .STACK_DEPTH  (STACK_DEPTH),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cmd_pos_i       (cmd_pos),
    .cmd_pop_o       (cmd_pop),
    .res_valid_o     (m_axis_tvalid_o),
    .res_ready_i     (m_axis_tready_i),
    .res_status_o    (res_status),
    .res_has_entry_o (res_has),
    .res_kind_o      (res_kind),
    .res_closing_o   (res_closing),
    .res_pos_o       (res_pos),
    .res_last_o      (m_axis_tlast_o),
    .stat_o          (bk_stat)
  );

  assign m_axis_tdata_o = {{(bbc_pkg::OUT_TDATA_W - PW - 3){1'b0}},
                           res_pos, res_closing, res_kind};
  assign m_axis_tuser_o = {res_has, res_status};

`ifndef ASSERT_OFF
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fr_stat.level <= bbc_pkg::QUEUE_LW'(bbc_pkg::QUEUE_DEPTH))
    else $error("command queue level out of range");

  a_pop_needs_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd.valid)
    else $error("back took a command from an empty queue");

  a_no_pop_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.draining |-> !cmd_pop)
    else $error("command taken while the verdict drains");

  a_drain_goes_on : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |-> bk_stat.draining)
    else $error("verdict ended without a final item");
`endif

endmodule
